[design/lcs_pkg.sv]
`timescale 1ns / 1ps
package lcs_pkg;
   localparam int UNITS = 32;
   localparam int COLS = UNITS + 2;
   localparam int UW = $clog2(UNITS);
   localparam int CW = $clog2(COLS);
   localparam int GW = 2;
   localparam int ADDR_W = GW + UW + CW;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int ACC_W = 48;

   typedef enum logic [1:0] {
      FUNC_LOAD_W = 2'd0,
      FUNC_LOAD_H = 2'd1,
      FUNC_COMPUTE = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ACT,
      ST_CELL,
      ST_HID,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic enable;
      logic signed [15:0] op_a;
      logic signed [15:0] op_b;
   } mac_ctl_type;

   function automatic logic signed [15:0] to_q12(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = (v + ACC_W'(2048)) >>> 12;
      if (r > ACC_W'(32767)) return 16'sh7fff;
      else if (r < -ACC_W'(32768)) return 16'sh8000;
      else return r[15:0];
   endfunction

   function automatic logic [4:0] sig_idx(input logic signed [15:0] q);
      logic signed [19:0] t;
      logic [19:0] d;
      t = 20'(5 * 20'(q)) + 20'sd122880;
      d = 20'(t) >> 13;
      if (t < 0) return 5'd0;
      else if (d >= 20'd30) return 5'd31;
      else return 5'(d + 20'd1);
   endfunction

   function automatic logic [4:0] tanh_idx(input logic signed [15:0] q);
      logic signed [19:0] t;
      logic [19:0] d;
      t = 20'(5 * 20'(q)) + 20'sd61440;
      d = 20'(t) >> 12;
      if (t < 0) return 5'd0;
      else if (d >= 20'd30) return 5'd31;
      else return 5'(d + 20'd1);
   endfunction

   function automatic logic signed [15:0] sig_lut(input logic [4:0] i);
      logic signed [15:0] t [32];
      t = '{0, 12, 18, 27, 41, 61, 90, 132, 194, 283, 409, 581, 810, 1102, 1451,
            1844, 2252, 2645, 2994, 3286, 3515, 3687, 3813, 3902, 3964, 4006,
            4035, 4055, 4069, 4078, 4084, 4096};
      return t[i];
   endfunction

   function automatic logic signed [15:0] tanh_code(input logic [4:0] i);
      logic signed [15:0] t [32];
      t = '{-4096, -4071, -4059, -4041, -4014, -3975, -3917, -3831, -3707, -3530,
            -3279, -2934, -2475, -1893, -1193, -408, 408, 1193, 1893, 2475, 2934,
            3279, 3530, 3707, 3831, 3917, 3975, 4014, 4041, 4059, 4071, 4096};
      return t[i];
   endfunction
endpackage

[design/lcs_ram.sv]
`timescale 1ns / 1ps
module lcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[design/lcs_mac.sv]
`timescale 1ns / 1ps
module lcs_mac (
   input  logic                                   clock,
   input  lcs_pkg::mac_ctl_type                    ctl,
   output logic signed [lcs_pkg::ACC_W-1:0]        acc
);
   logic signed [31:0] prod_ff;
   logic signed [31:0] prod_in;
   logic en_ff;
   logic signed [lcs_pkg::ACC_W-1:0] acc_ff;
   logic signed [lcs_pkg::ACC_W-1:0] acc_in;

   always_comb begin
      prod_in = ctl.op_a * ctl.op_b;
      acc_in = acc_ff;
      if (ctl.clear) acc_in = '0;
      else if (en_ff) acc_in = acc_ff + lcs_pkg::ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      en_ff <= ctl.enable;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

[design/lstm_cell_step.sv]
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)                                         | user
// req     | in  | func, unit_index, weight_gate, weight_column, load_value, x, cell_prev | -
// rsp     | out | hidden_out, cell_out                                              | -
// Load beats are accepted whenever the block is idle. For a compute beat, per gate
// 34 reads stream through one 16x16 multiply-accumulate unit, then drain and activation
// steps follow; after the four gates come the cell, hidden and output steps.
// Reset is synchronous; stores hold garbage until loaded. req_tready stays low
// while a compute runs; a result waiting on rsp_tready holds the next compute
// at its cell update.
module lstm_cell_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // func[1:0] unit[6:2] gate[8:7] col[14:9] load[30:15] x[46:31] cprev[62:47]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // hidden_out[15:0] cell_out[31:16]
);
   localparam int UW = lcs_pkg::UW;
   localparam int CW = lcs_pkg::CW;
   localparam int AW = lcs_pkg::ADDR_W;

   logic [1:0] func;
   logic [UW-1:0] in_unit;
   logic [1:0] in_gate;
   logic [5:0] in_col;
   logic signed [15:0] load_value, x_input, cell_prev;
   assign func = req_tdata[1:0];
   assign in_unit = req_tdata[2 +: UW];
   assign in_gate = req_tdata[8:7];
   assign in_col = req_tdata[14:9];
   assign load_value = req_tdata[30:15];
   assign x_input = req_tdata[46:31];
   assign cell_prev = req_tdata[62:47];

   lcs_pkg::state_type state_ff, state_in;
   logic [UW-1:0] unit_ff, unit_in;
   logic signed [15:0] x_ff, x_in, cp_ff, cp_in;
   logic [1:0] g_ff, g_in;
   logic [CW-1:0] c_ff, c_in;
   logic [1:0] dr_ff, dr_in;
   logic signed [15:0] act_ff [4];
   logic signed [15:0] act_in [4];
   logic signed [15:0] cell_ff, cell_in, hid_ff, hid_in;
   logic rv_ff, rv_in;
   logic [CW-1:0] cprev_ff;
   logic issue_ff;

   logic acc_w;
   logic wr_w, wr_h;
   logic [AW-1:0] w_waddr, w_raddr;
   logic [15:0] w_rd, h_rd;
   logic [UW-1:0] h_raddr;
   lcs_pkg::mac_ctl_type ctl;
   logic signed [lcs_pkg::ACC_W-1:0] acc;
   logic signed [15:0] gsum;

   assign acc_w = req_tvalid && req_tready;
   assign wr_w = acc_w && func == lcs_pkg::FUNC_LOAD_W && in_col < 6'(lcs_pkg::COLS);
   assign wr_h = acc_w && func == lcs_pkg::FUNC_LOAD_H;
   assign w_waddr = {in_gate, in_unit, in_col[CW-1:0]};
   assign w_raddr = {g_ff, unit_ff, c_ff};
   assign h_raddr = c_ff[UW-1:0];

   lcs_ram #(.WIDTH(16), .DEPTH(lcs_pkg::STORE_DEPTH)) u_wram (
      .clock(clock), .wr_en(wr_w), .wr_addr(w_waddr), .wr_data(load_value),
      .rd_addr(w_raddr), .rd_data(w_rd));
   lcs_ram #(.WIDTH(16), .DEPTH(lcs_pkg::UNITS)) u_hram (
      .clock(clock), .wr_en(wr_h), .wr_addr(in_unit), .wr_data(load_value),
      .rd_addr(h_raddr), .rd_data(h_rd));

   lcs_mac u_mac (.clock(clock), .ctl(ctl), .acc(acc));

   assign gsum = lcs_pkg::to_q12(acc);

   always_ff @(posedge clock) begin
      cprev_ff <= c_ff;
      issue_ff <= state_ff == lcs_pkg::ST_ISSUE;
   end

   always_comb begin
      state_in = state_ff;
      unit_in = unit_ff; x_in = x_ff; cp_in = cp_ff;
      g_in = g_ff; c_in = c_ff; dr_in = dr_ff;
      act_in = act_ff; cell_in = cell_ff; hid_in = hid_ff; rv_in = rv_ff;
      req_tready = state_ff == lcs_pkg::ST_IDLE;
      ctl.clear = 1'b0;
      ctl.enable = 1'b0;
      ctl.op_a = 16'(w_rd);
      ctl.op_b = 16'(h_rd);
      if (cprev_ff == CW'(lcs_pkg::UNITS)) ctl.op_b = x_ff;
      else if (cprev_ff == CW'(lcs_pkg::UNITS + 1)) ctl.op_b = 16'sd4096;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         lcs_pkg::ST_IDLE: begin
            if (acc_w && func == lcs_pkg::FUNC_COMPUTE) begin
               unit_in = in_unit; x_in = x_input; cp_in = cell_prev;
               g_in = '0; c_in = '0; ctl.clear = 1'b1;
               state_in = lcs_pkg::ST_ISSUE;
            end
         end
         lcs_pkg::ST_ISSUE: begin
            // RAM read data lands in the next cycle; feed MAC from issue_ff
            ctl.enable = issue_ff;
            if (c_ff == CW'(lcs_pkg::COLS - 1)) begin
               dr_in = '0;
               state_in = lcs_pkg::ST_DRAIN;
            end else c_in = c_ff + 1'b1;
         end
         lcs_pkg::ST_DRAIN: begin
            ctl.enable = dr_ff == 2'd0;
            dr_in = dr_ff + 1'b1;
            if (dr_ff == 2'd2) state_in = lcs_pkg::ST_ACT;
         end
         lcs_pkg::ST_ACT: begin
            if (g_ff == 2'd2) act_in[g_ff] = lcs_pkg::tanh_code(lcs_pkg::tanh_idx(gsum));
            else act_in[g_ff] = lcs_pkg::sig_lut(lcs_pkg::sig_idx(gsum));
            ctl.clear = 1'b1;
            c_in = '0;
            if (g_ff == 2'd3) state_in = lcs_pkg::ST_CELL;
            else begin
               g_in = g_ff + 1'b1;
               state_in = lcs_pkg::ST_ISSUE;
            end
         end
         lcs_pkg::ST_CELL: begin
            // hold until the previous result has left the output registers
            if (!rv_ff) begin
               cell_in = lcs_pkg::to_q12(lcs_pkg::ACC_W'(cp_ff * act_ff[0])
                                       + lcs_pkg::ACC_W'(act_ff[1] * act_ff[2]));
               state_in = lcs_pkg::ST_HID;
            end
         end
         lcs_pkg::ST_HID: begin
            hid_in = lcs_pkg::to_q12(lcs_pkg::ACC_W'(act_ff[3]
                        * lcs_pkg::tanh_code(lcs_pkg::tanh_idx(cell_ff))));
            state_in = lcs_pkg::ST_OUT;
         end
         lcs_pkg::ST_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = lcs_pkg::ST_IDLE;
            end
         end
         default: state_in = lcs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcs_pkg::ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
      unit_ff <= unit_in; x_ff <= x_in; cp_ff <= cp_in;
      g_ff <= g_in; c_ff <= c_in; dr_ff <= dr_in;
      act_ff <= act_in; cell_ff <= cell_in; hid_ff <= hid_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {cell_ff, hid_ff};
endmodule
